[rtl/bidq_pkg.sv]
package bidq_pkg;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_INS_HEAD  = 3'd0;
    localparam logic [2:0] MODE_INS_TAIL  = 3'd1;
    localparam logic [2:0] MODE_REM_HEAD  = 3'd2;
    localparam logic [2:0] MODE_REM_TAIL  = 3'd3;
    localparam logic [2:0] MODE_READ      = 3'd4;
    localparam logic [2:0] MODE_REPLACE   = 3'd5;
    localparam logic [2:0] MODE_PEEK_HEAD = 3'd6;
    localparam logic [2:0] MODE_PEEK_TAIL = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Fixed field widths of the stream beats
    localparam int MODE_W  = 3;
    localparam int POS_W   = 8;
    localparam int ITEM_W  = 32;
    localparam int OCC_W   = 9;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Result bookkeeping that travels alongside the memory read
    typedef struct packed {
        logic              rd_used;
        logic [OCC_W-1:0]  occupancy;
        logic [STAT_W-1:0] status;
    } bidq_meta_t;

endpackage

[rtl/bounded_indexed_deque_core.sv]
// Bounded indexed deque: a list of up to CAPACITY element words kept in one
// single-port synchronous RAM addressed through a circular head pointer. Each
// input beat carries one operation (insert/remove at head or tail, read or
// replace at a logical index, peek at head or tail) and produces exactly one
// output beat with the word read (zero unless a read or peek succeeded), the
// occupancy after the operation and a status (ok, full, empty, out of range).
// A failed operation changes nothing. Head pointer and count update on the
// accepting edge, the RAM is accessed in that same cycle, and the registered
// read word joins its result in the output register when stage 1 advances.
// One operation is accepted every cycle while the output side keeps up: the
// single RAM port carries one access per operation, and back-to-back
// accesses to the same slot are ordered by the RAM itself. No clearing pass
// is needed after reset.
module bounded_indexed_deque_core #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode[2:0], position[10:3], item_value[42:11], zero pad[47:43]
    input  logic [bidq_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_value[31:0], occupancy[40:32], status[42:41], zero pad[47:43]
    output logic [bidq_pkg::M_DATA_W-1:0]     m_tdata
);

    import bidq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_value;

    logic                     accept_in, advance;
    logic                     mem_we, mem_re;
    logic [PTR_W-1:0]         mem_addr;
    logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;
    bidq_meta_t               meta;

    // stage 1: RAM read in flight
    logic       p1_valid_reg, p1_valid_next;
    bidq_meta_t p1_meta_reg;

    // stage 2: output register
    logic              out_valid_reg, out_valid_next;
    logic [ITEM_W-1:0] out_read_reg;
    logic [OCC_W-1:0]  out_occ_reg;
    logic [STAT_W-1:0] out_stat_reg;

    assign mode       = s_tdata[MODE_W-1:0];
    assign position   = s_tdata[MODE_W+POS_W-1:MODE_W];
    assign item_value = s_tdata[MODE_W+POS_W+ITEM_W-1:MODE_W+POS_W];

    // advance stage 1 whenever the output register is free or being drained
    assign advance   = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !p1_valid_reg || advance;
    assign accept_in = s_tvalid && s_tready;

    bidq_ctrl #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .PTR_W         (PTR_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept_in),
        .mode       (mode),
        .position   (position),
        .item_value (item_value),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .meta       (meta)
    );

    bidq_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ELEMENT_WIDTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (accept_in)
        begin
            p1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            p1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: hold the meta with its read, then drop the read word in on advance
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            p1_meta_reg <= meta;
        end
        if (advance)
        begin
            out_read_reg <= p1_meta_reg.rd_used ? ITEM_W'(mem_rdata) : '0;
            out_occ_reg  <= p1_meta_reg.occupancy;
            out_stat_reg <= p1_meta_reg.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - ITEM_W - OCC_W - STAT_W){1'b0}},
                       out_stat_reg, out_occ_reg, out_read_reg};

endmodule

[rtl/bidq_ram.sv]
module bidq_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[addr] <= wdata;
        end
        // hold the last read word until the next read
        if (re)
        begin
            rd_data_reg <= store_mem[addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

[rtl/bidq_ctrl.sv]
module bidq_ctrl #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32,
    parameter int PTR_W         = 8,
    parameter int CNT_W         = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [bidq_pkg::MODE_W-1:0]     mode,
    input  logic [bidq_pkg::POS_W-1:0]      position,
    input  logic [bidq_pkg::ITEM_W-1:0]     item_value,
    output logic                            mem_we,
    output logic                            mem_re,
    output logic [PTR_W-1:0]                mem_addr,
    output logic [ELEMENT_WIDTH-1:0]        mem_wdata,
    output bidq_pkg::bidq_meta_t            meta
);

    import bidq_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W = CNT_W + 1;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             full, empty, pos_ok;
    logic [PTR_W-1:0] head_dec, head_inc;
    logic [CNT_W-1:0] offset;
    logic [SUM_W-1:0] slot_sum, slot_wrap;
    logic [PTR_W-1:0] slot;
    logic             we, re, rd_used;
    logic [1:0]       status;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign pos_ok = (CMP_W'(position) < CMP_W'(count_reg));

    assign head_dec = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // offset from head; wrap once since head + offset < 2 * CAPACITY whenever the operation succeeds
    always_comb
    begin
        case (mode)
            MODE_INS_TAIL:  offset = count_reg;
            MODE_READ,
            MODE_REPLACE:   offset = CNT_W'(position);
            MODE_PEEK_TAIL: offset = count_reg - 1'b1;
            default:        offset = '0;
        endcase
    end

    assign slot_sum  = SUM_W'(head_reg) + SUM_W'(offset);
    assign slot_wrap = (slot_sum >= SUM_W'(CAPACITY)) ? slot_sum - SUM_W'(CAPACITY)
                                                      : slot_sum;
    assign slot      = PTR_W'(slot_wrap);

    always_comb
    begin
        we         = 1'b0;
        re         = 1'b0;
        rd_used    = 1'b0;
        status     = ST_OK;
        head_next  = head_reg;
        count_next = count_reg;
        mem_addr   = slot;
        case (mode)
            MODE_INS_HEAD:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    mem_addr   = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_INS_TAIL:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_REM_HEAD:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_REM_TAIL:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_READ:
            begin
                if (!pos_ok)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    re      = 1'b1;
                    rd_used = 1'b1;
                end
            end
            MODE_REPLACE:
            begin
                if (!pos_ok)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    we = 1'b1;
                end
            end
            MODE_PEEK_HEAD,
            MODE_PEEK_TAIL:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    re      = 1'b1;
                    rd_used = 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign mem_we         = accept && we;
    assign mem_re         = accept && re;
    assign mem_wdata      = ELEMENT_WIDTH'(item_value);
    assign meta.rd_used   = rd_used;
    assign meta.occupancy = OCC_W'(count_next);
    assign meta.status    = status;

endmodule

[rtl/bidq_checker.sv]
module bidq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bidq_pkg::M_DATA_W-1:0] m_tdata
);

    import bidq_pkg::*;

    logic [1:0]  out_status;
    logic [8:0]  out_occ;
    logic [31:0] out_read;

    assign out_read   = m_tdata[31:0];
    assign out_occ    = m_tdata[40:32];
    assign out_status = m_tdata[42:41];

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // an empty status leaves nothing held and no word read
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status == ST_EMPTY |-> out_occ == '0 && out_read == '0)
        else $error("empty status with data or occupancy");

    // a range failure returns no word
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status == ST_RANGE |-> out_read == '0)
        else $error("range status with nonzero read word");

    // a fresh output beat traces back to an accepted input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output beat without a matching input beat");

    // the output pad bits stay zero on every valid output beat
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:43] == '0)
        else $error("output pad bits not zero");

endmodule

bind bounded_indexed_deque_core bidq_checker u_bidq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
